// ===== src/maze_dfs_path_solver_defines.svh =====
// Assertion macros for the maze solver.
// Included by the top level; no other dependencies.
`ifndef MAZE_DFS_PATH_SOLVER_DEFINES_SVH
`define MAZE_DFS_PATH_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define MDS_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("maze solver check failed");
`define MDS_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("maze solver check failed");
`else
`define MDS_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons)
`define MDS_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== src/mds_pkg.sv =====
// Shared types and constants of the maze solver.
// No dependencies.
package mds_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 12;
  localparam int LEN_W     = 13;

  localparam logic [CFG_W-1:0] SIDE_MIN   = 7'd3;
  localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 2'd0,
    CMD_SOLVE     = 2'd1,
    CMD_READ_CELL = 2'd2,
    CMD_READ_PATH = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_START,
    ST_TOP,
    ST_CHECK,
    ST_POP_WAIT,
    ST_READ_WAIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic visited;
    logic on_path;
  } mark_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] length;
    logic             on_path;
    logic             visited;
    logic [IDX_W-1:0] path_cell;
  } result_t;

endpackage

// ===== src/mds_ifs.sv =====
// Request and result channel interfaces of the maze solver.
// Depends on mds_pkg.
interface mds_in_if;
  logic                         valid;
  logic                         ready;
  logic [mds_pkg::CMD_W-1:0]    command;
  logic [mds_pkg::IDX_W-1:0]    cell_index;
  logic                         is_wall;

  modport source (output valid, command, cell_index, is_wall, input ready);
  modport sink   (input valid, command, cell_index, is_wall, output ready);
endinterface

interface mds_out_if;
  logic                         valid;
  logic                         ready;
  logic                         path_found;
  logic [mds_pkg::LEN_W-1:0]    path_length;
  logic                         cell_on_path;
  logic                         cell_visited;
  logic [mds_pkg::IDX_W-1:0]    path_cell;

  modport source (output valid, path_found, path_length, cell_on_path, cell_visited,
                  path_cell, input ready);
  modport sink   (input valid, path_found, path_length, cell_on_path, cell_visited,
                  path_cell, output ready);
endinterface

// ===== src/maze_dfs_path_solver.sv =====
// Depth-first maze solver top level: command sequencer, wall and path stack memories.
// Depends on mds_pkg, mds_ifs, mds_mark_mem and maze_dfs_path_solver_defines.svh.
//
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | command, cell_index, is_wall
//  out_ch   | out | valid/ready        | path_found, path_length, cell_on_path,
//           |     |                    | cell_visited, path_cell
//  cfg_*    | in  | cfg_we, no stall   | cfg_index, cfg_wdata
//
// Load writes the wall memory and responds; read cell and read path wait on a registered
// memory read. Solve clears the marks, seeds the walk at the entry cell, then per step
// skips each out-of-grid direction, probes each in-grid neighbour (wall and mark read) and
// reads the stack on each backtrack.
// After reset a mark clearing pass runs before the first request is taken.
// One request at a time; the next is taken while a result still waits on out_ch.
`include "maze_dfs_path_solver_defines.svh"

module maze_dfs_path_solver #(
  parameter int MAX_CELLS = 4096,
  parameter int MAX_SIDE  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mds_in_if.sink                        in_ch,
  mds_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mds_pkg::CFG_W-1:0]     cfg_wdata
);
  import mds_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);
  localparam int DW = $clog2(MAX_CELLS + 1);
  localparam int CW = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam int EW = 2 * CFG_W;
  localparam int XW = (AW > EW) ? AW : EW;

  logic             wall_mem [MAX_CELLS];
  logic [AW-1:0]    stk_mem  [MAX_CELLS];

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] cfg_cols_r, cfg_rows_r;
  logic [CFG_W-1:0] cols_r, cols_nxt, rows_r, rows_nxt;
  logic [CFG_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [EW-1:0]    exit_r, exit_nxt;
  logic [AW-1:0]    here_r, here_nxt, nb_r, nb_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic             solved_r, solved_nxt;
  dir_t             dir_r, dir_nxt;
  cmd_t             req_cmd_r;
  logic [IDX_W-1:0] req_idx_r;
  logic             req_wall_r;
  logic             cell_ok_r, cell_ok_nxt, path_ok_r, path_ok_nxt;
  logic             res_on_r, res_on_nxt, res_vis_r, res_vis_nxt;
  logic [IDX_W-1:0] res_pcell_r, res_pcell_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;
  logic             res_load;

  logic             wall_rd_r, stk_we, wall_we;
  logic [AW-1:0]    stk_rd_r;
  logic [AW-1:0]    wall_rd_addr, stk_rd_addr, stk_wr_addr, stk_wr_data;
  logic             mark_we, clr_start, clr_busy;
  logic [AW-1:0]    mark_wr_addr, mark_rd_addr;
  mark_t            mark_wr_data, mark_rd;

  logic             in_rdy, enter_w, do_pop, bound_ok, nb_ok;
  logic [CW-1:0]    here_w, cols_w, nb_w, prev_w;

  mds_mark_mem #(.Depth(MAX_CELLS)) u_marks (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (clr_start),
    .clr_busy  (clr_busy),
    .wr_en     (mark_we),
    .wr_addr   (mark_wr_addr),
    .wr_data   (mark_wr_data),
    .rd_addr   (mark_rd_addr),
    .rd_data   (mark_rd)
  );

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[AW'(req_idx_r)] <= req_wall_r;
    end
    wall_rd_r <= wall_mem[wall_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    stk_rd_r <= stk_mem[stk_rd_addr];
  end

  always_comb begin
    here_w   = CW'(here_r);
    cols_w   = CW'(cols_r);
    prev_w   = CW'(stk_rd_r);
    bound_ok = 1'b0;
    nb_w     = here_w;
    case (dir_r)
      DIR_RIGHT: begin
        bound_ok = ({1'b0, col_r} + 1'b1) < {1'b0, cols_r};
        nb_w     = here_w + 1'b1;
      end
      DIR_DOWN: begin
        bound_ok = ({1'b0, row_r} + 1'b1) < {1'b0, rows_r};
        nb_w     = here_w + cols_w;
      end
      DIR_UP: begin
        bound_ok = (row_r != '0);
        nb_w     = here_w - cols_w;
      end
      DIR_LEFT: begin
        bound_ok = (col_r != '0);
        nb_w     = here_w - 1'b1;
      end
      default: begin
        bound_ok = 1'b0;
      end
    endcase
    nb_ok = bound_ok && (nb_w < CW'(MAX_CELLS));
  end

  always_comb begin
    state_nxt     = state_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    exit_nxt      = exit_r;
    here_nxt      = here_r;
    nb_nxt        = nb_r;
    depth_nxt     = depth_r;
    solved_nxt    = solved_r;
    dir_nxt       = dir_r;
    cell_ok_nxt   = cell_ok_r;
    path_ok_nxt   = path_ok_r;
    res_on_nxt    = res_on_r;
    res_vis_nxt   = res_vis_r;
    res_pcell_nxt = res_pcell_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    res_load      = 1'b0;
    in_rdy        = (state_r == ST_IDLE);
    wall_we       = 1'b0;
    wall_rd_addr  = AW'(nb_w);
    stk_we        = 1'b0;
    stk_wr_addr   = AW'(depth_r);
    stk_wr_data   = nb_r;
    stk_rd_addr   = AW'(depth_r - DW'(2));
    mark_we       = 1'b0;
    mark_wr_addr  = here_r;
    mark_wr_data  = '0;
    mark_rd_addr  = AW'(nb_w);
    clr_start     = 1'b0;
    enter_w       = 1'b0;
    do_pop        = 1'b0;

    case (state_r)
      ST_INIT: begin
        if (!clr_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_on_nxt    = 1'b0;
        res_vis_nxt   = 1'b0;
        res_pcell_nxt = '0;
        cell_ok_nxt   = 1'b0;
        path_ok_nxt   = 1'b0;
        mark_rd_addr  = AW'(req_idx_r);
        stk_rd_addr   = AW'(req_idx_r);
        case (req_cmd_r)
          CMD_LOAD: begin
            wall_we   = (32'(req_idx_r) < MAX_CELLS);
            state_nxt = ST_RESP;
          end
          CMD_SOLVE: begin
            clr_start  = 1'b1;
            solved_nxt = 1'b0;
            depth_nxt  = '0;
            if (cfg_cols_r < SIDE_MIN) begin
              cols_nxt = SIDE_MIN;
            end else if (32'(cfg_cols_r) > MAX_SIDE) begin
              cols_nxt = CFG_W'(MAX_SIDE);
            end else begin
              cols_nxt = cfg_cols_r;
            end
            if (cfg_rows_r < SIDE_MIN) begin
              rows_nxt = SIDE_MIN;
            end else if (32'(cfg_rows_r) > MAX_SIDE) begin
              rows_nxt = CFG_W'(MAX_SIDE);
            end else begin
              rows_nxt = cfg_rows_r;
            end
            state_nxt = ST_CLEAR;
          end
          CMD_READ_CELL: begin
            cell_ok_nxt = (32'(req_idx_r) < MAX_CELLS);
            state_nxt   = ST_READ_WAIT;
          end
          CMD_READ_PATH: begin
            path_ok_nxt = solved_r && (32'(req_idx_r) < 32'(depth_r));
            state_nxt   = ST_READ_WAIT;
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (32'(cols_r) >= MAX_CELLS) begin
          state_nxt = ST_RESP;
        end else begin
          mark_we      = 1'b1;
          mark_wr_addr = AW'(cols_r);
          mark_wr_data = '{visited: 1'b1, on_path: 1'b1};
          stk_we       = 1'b1;
          stk_wr_addr  = '0;
          stk_wr_data  = AW'(cols_r);
          depth_nxt    = DW'(1);
          here_nxt     = AW'(cols_r);
          col_nxt      = '0;
          row_nxt      = CFG_W'(1);
          dir_nxt      = DIR_RIGHT;
          exit_nxt     = EW'(cols_r) * EW'(rows_r - 1'b1) - EW'(1);
          state_nxt    = ST_TOP;
        end
      end
      ST_TOP: begin
        if (XW'(here_r) == XW'(exit_r)) begin
          solved_nxt = 1'b1;
          state_nxt  = ST_RESP;
        end else if (nb_ok) begin
          nb_nxt    = AW'(nb_w);
          state_nxt = ST_CHECK;
        end else if (dir_r == DIR_LEFT) begin
          do_pop = 1'b1;
        end else begin
          dir_nxt = dir_t'(dir_r + 2'd1);
        end
      end
      ST_CHECK: begin
        if (!wall_rd_r && !mark_rd.visited) begin
          enter_w      = 1'b1;
          mark_we      = 1'b1;
          mark_wr_addr = nb_r;
          mark_wr_data = '{visited: 1'b1, on_path: 1'b1};
          stk_we       = 1'b1;
          depth_nxt    = depth_r + 1'b1;
          here_nxt     = nb_r;
          dir_nxt      = DIR_RIGHT;
          state_nxt    = ST_TOP;
          case (dir_r)
            DIR_RIGHT: col_nxt = col_r + 1'b1;
            DIR_DOWN:  row_nxt = row_r + 1'b1;
            DIR_UP:    row_nxt = row_r - 1'b1;
            DIR_LEFT:  col_nxt = col_r - 1'b1;
            default:   col_nxt = col_r;
          endcase
        end else if (dir_r == DIR_LEFT) begin
          do_pop = 1'b1;
        end else begin
          dir_nxt   = dir_t'(dir_r + 2'd1);
          state_nxt = ST_TOP;
        end
      end
      ST_POP_WAIT: begin
        if (prev_w == here_w - 1'b1) begin
          col_nxt = col_r - 1'b1;
        end else if (prev_w == here_w + 1'b1) begin
          col_nxt = col_r + 1'b1;
        end else if (prev_w == here_w - cols_w) begin
          row_nxt = row_r - 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
        here_nxt  = stk_rd_r;
        dir_nxt   = DIR_RIGHT;
        state_nxt = ST_TOP;
      end
      ST_READ_WAIT: begin
        res_on_nxt    = cell_ok_r && mark_rd.on_path;
        res_vis_nxt   = cell_ok_r && mark_rd.visited;
        res_pcell_nxt = path_ok_r ? IDX_W'(stk_rd_r) : '0;
        state_nxt     = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          res_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_pop) begin
      mark_we      = 1'b1;
      mark_wr_addr = here_r;
      mark_wr_data = '{visited: 1'b1, on_path: 1'b0};
      depth_nxt    = depth_r - 1'b1;
      state_nxt    = (depth_r == DW'(1)) ? ST_RESP : ST_POP_WAIT;
    end

    if (res_load) begin
      res_nxt.found     = solved_r;
      res_nxt.length    = solved_r ? LEN_W'(depth_r) : '0;
      res_nxt.on_path   = res_on_r;
      res_nxt.visited   = res_vis_r;
      res_nxt.path_cell = res_pcell_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      depth_r     <= '0;
      solved_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dir_r       <= DIR_RIGHT;
      cfg_cols_r  <= SIDE_RESET;
      cfg_rows_r  <= SIDE_RESET;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      solved_r    <= solved_nxt;
      out_valid_r <= out_valid_nxt;
      dir_r       <= dir_nxt;
      if (cfg_we && cfg_index == REG_COLUMNS) begin
        cfg_cols_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_ROWS) begin
        cfg_rows_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      req_cmd_r  <= cmd_t'(in_ch.command);
      req_idx_r  <= in_ch.cell_index;
      req_wall_r <= in_ch.is_wall;
    end
    cols_r      <= cols_nxt;
    rows_r      <= rows_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    exit_r      <= exit_nxt;
    here_r      <= here_nxt;
    nb_r        <= nb_nxt;
    cell_ok_r   <= cell_ok_nxt;
    path_ok_r   <= path_ok_nxt;
    res_on_r    <= res_on_nxt;
    res_vis_r   <= res_vis_nxt;
    res_pcell_r <= res_pcell_nxt;
    res_r       <= res_nxt;
  end

  assign in_ch.ready         = in_rdy;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.path_found   = res_r.found;
  assign out_ch.path_length  = res_r.length;
  assign out_ch.cell_on_path = res_r.on_path;
  assign out_ch.cell_visited = res_r.visited;
  assign out_ch.path_cell    = res_r.path_cell;

  `MDS_ASSERT_IMPL(a_ready_not_clearing, clk, rst_n, in_rdy, !clr_busy)
  `MDS_ASSERT_IMPL(a_solved_has_path, clk, rst_n, solved_r, depth_r != '0)
  `MDS_ASSERT_NEXT(a_push_grows_stack, clk, rst_n, enter_w, depth_r == $past(depth_r) + 1'b1)

endmodule

// ===== src/mds_mark_mem.sv =====
// Visited and on-path mark memory with a clearing sweep after reset and on demand.
// Depends on mds_pkg.
module mds_mark_mem #(
  parameter int  Depth = 4096,
  localparam int AW    = $clog2(Depth)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr_start,
  output logic            clr_busy,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  mds_pkg::mark_t  wr_data,
  input  logic [AW-1:0]   rd_addr,
  output mds_pkg::mark_t  rd_data
);
  import mds_pkg::*;

  mark_t         mem [Depth];
  mark_t         rd_data_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_start) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(Depth - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign clr_busy = clr_active_r;
  assign rd_data  = rd_data_r;

endmodule
